>>> rtl/dts_pkg.sv
package dts_pkg;

    localparam int unsigned VERTEX_W = 5;
    localparam int unsigned CFG_W    = 6;

    localparam logic [CFG_W-1:0] CFG_RESET = 6'd32;

    localparam logic       CMD_EDGE     = 1'b0;
    localparam logic       CMD_SORT     = 1'b1;
    localparam logic       KIND_ACK     = 1'b0;
    localparam logic       KIND_VERTEX  = 1'b1;
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_RANGE = 2'd2;

    typedef struct packed {
        logic                cmd;
        logic [VERTEX_W-1:0] src_vertex;
        logic [VERTEX_W-1:0] dst_vertex;
    } t_dts_in;

    typedef struct packed {
        logic                kind;
        logic [1:0]          status;
        logic [VERTEX_W-1:0] vertex;
        logic                last;
    } t_dts_out;

    typedef struct packed {
        logic [VERTEX_W-1:0] src;
        logic [VERTEX_W-1:0] dst;
    } t_dts_edge;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_CHECK,
        ST_FINISH,
        ST_RESTORE,
        ST_EMIT_RD,
        ST_EMIT_SEND
    } t_dts_state;

    // controller -> datapath
    typedef struct packed {
        logic cfg_write;
        logic accept_edge;
        logic start_sort;
        logic skip_start;
        logic enter_start;
        logic scan_next;
        logic push;
        logic finish;
        logic restore;
        logic emit_init;
        logic emit_load;
    } t_dts_cmd;

    // datapath -> controller
    typedef struct packed {
        logic hit;
        logic j_end;
        logic cnt_zero;
        logic sp_zero;
        logic x_end;
        logic x_visited;
        logic done_zero;
        logic k_zero;
        logic rest_end;
        logic out_free;
    } t_dts_sts;

endpackage

>>> rtl/dfs_topological_sort.sv
// Depth-first topological sort. A cmd 0 transaction appends one directed edge and
// returns one acknowledgement in the cycle after it is accepted; bad endpoints
// (checked against num_vertices, capped at MAX_VERTICES) and a full table are
// flagged and the edge is dropped. A cmd 1 transaction runs the search over the
// stored edges and returns the vertices in reverse finish order, the final one
// marked last. The edge table is a single-read memory scanned one edge per cycle,
// and every vertex that is reached rescans the table from its resume point, so the
// scan work grows with the number of vertices reached times the number of stored
// edges; each vertex is then read from the finish-order memory before it is sent.
// Only one transaction is in flight at a time; num_vertices may be written only
// while the block is idle.
module dfs_topological_sort #(
    parameter int unsigned MAX_VERTICES = 32,
    parameter int unsigned MAX_EDGES    = 128
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  dts_pkg::t_dts_in           i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output dts_pkg::t_dts_out          o_out_data,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [dts_pkg::CFG_W-1:0]  i_cfg_data
);
    import dts_pkg::*;

    t_dts_cmd cmd;
    t_dts_sts sts;

    dts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_cmd    (i_in_data.cmd),
        .i_cfg_valid (i_cfg_valid),
        .i_sts       (sts),
        .o_in_stall  (o_in_stall),
        .o_cfg_ready (o_cfg_ready),
        .o_cmd       (cmd)
    );

    dts_datapath #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_EDGES    (MAX_EDGES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_data   (i_in_data),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    a_edge_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.accept_edge |=> o_out_valid && o_out_data.last && o_out_data.kind == KIND_ACK)
        else $error("edge transaction did not produce a final acknowledgement");

    a_sort_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.start_sort |=> !sts.x_visited && sts.sp_zero && sts.done_zero)
        else $error("search state not cleared at start of sort");

    a_push_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.push |=> !sts.sp_zero)
        else $error("stack empty right after a push");

    a_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit_load |=> o_out_valid && o_out_data.kind == KIND_VERTEX
                          && o_out_data.status == STATUS_OK)
        else $error("sorted vertex not presented after load");

endmodule

>>> rtl/dts_datapath.sv
module dts_datapath #(
    parameter int unsigned MAX_VERTICES = 32,
    parameter int unsigned MAX_EDGES    = 128
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  dts_pkg::t_dts_cmd           i_cmd,
    output dts_pkg::t_dts_sts           o_sts,
    input  dts_pkg::t_dts_in            i_in_data,
    input  logic [dts_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                        i_out_stall,
    output logic                        o_out_valid,
    output dts_pkg::t_dts_out           o_out_data
);
    import dts_pkg::*;

    localparam int unsigned VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int unsigned LW = (VW + 1 > CFG_W) ? VW + 1 : CFG_W;
    localparam int unsigned CW = $clog2(MAX_EDGES + 1);
    localparam int unsigned AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int unsigned SW = VW + CW;

    logic [CFG_W-1:0]        r_cfg, n_cfg;
    logic [CW-1:0]           r_count, n_count;
    logic [MAX_VERTICES-1:0] r_visited, n_visited;
    logic [LW-1:0]           r_x, n_x;
    logic [LW-1:0]           r_done, n_done;
    logic [VW-1:0]           r_sp, n_sp;
    logic [VW-1:0]           r_k, n_k;
    logic [VW-1:0]           r_cur, n_cur;
    logic [CW-1:0]           r_j, n_j;
    logic                    r_out_valid, n_out_valid;
    t_dts_out                r_out, n_out;

    t_dts_edge               r_edge_mem [MAX_EDGES];
    logic [SW-1:0]           r_stk_mem [MAX_VERTICES];
    logic [VW-1:0]           r_fin_mem [MAX_VERTICES];
    t_dts_edge               r_edata;
    logic [SW-1:0]           r_sdata;
    logic [VW-1:0]           r_fdata;

    logic [LW-1:0]           lim;
    logic [LW-1:0]           in_src_x, in_dst_x;
    logic [1:0]              edge_status;
    logic [LW-1:0]           e_src_x, e_dst_x;
    logic                    e_hit;
    logic [CW:0]             j_inc;
    logic [VW-1:0]           s_vtx;
    logic [CW-1:0]           s_j;
    logic [LW-1:0]           f_ext;

    always_comb begin
        lim = (LW'(r_cfg) > LW'(MAX_VERTICES)) ? LW'(MAX_VERTICES) : LW'(r_cfg);

        in_src_x = LW'(i_in_data.src_vertex);
        in_dst_x = LW'(i_in_data.dst_vertex);
        if (in_src_x >= lim || in_dst_x >= lim) begin
            edge_status = STATUS_RANGE;
        end else if (r_count == CW'(MAX_EDGES)) begin
            edge_status = STATUS_FULL;
        end else begin
            edge_status = STATUS_OK;
        end

        e_src_x = LW'(r_edata.src);
        e_dst_x = LW'(r_edata.dst);
        e_hit   = (e_src_x == LW'(r_cur)) && (e_dst_x < lim)
                  && !r_visited[e_dst_x[VW-1:0]];
        j_inc   = {1'b0, r_j} + 1'b1;

        s_vtx   = r_sdata[SW-1:CW];
        s_j     = r_sdata[CW-1:0];
        f_ext   = LW'(r_fdata);
    end

    always_comb begin
        o_sts.hit       = e_hit;
        o_sts.j_end     = j_inc >= {1'b0, r_count};
        o_sts.cnt_zero  = r_count == '0;
        o_sts.sp_zero   = r_sp == '0;
        o_sts.x_end     = r_x == lim;
        o_sts.x_visited = r_visited[r_x[VW-1:0]];
        o_sts.done_zero = r_done == '0;
        o_sts.k_zero    = r_k == '0;
        o_sts.rest_end  = s_j >= r_count;
        o_sts.out_free  = !r_out_valid || !i_out_stall;
    end

    always_comb begin
        n_cfg       = r_cfg;
        n_count     = r_count;
        n_visited   = r_visited;
        n_x         = r_x;
        n_done      = r_done;
        n_sp        = r_sp;
        n_k         = r_k;
        n_cur       = r_cur;
        n_j         = r_j;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;

        if (i_cmd.cfg_write) begin
            n_cfg = i_cfg_data;
        end
        if (i_cmd.accept_edge) begin
            n_out_valid   = 1'b1;
            n_out.kind    = KIND_ACK;
            n_out.status  = edge_status;
            n_out.vertex  = '0;
            n_out.last    = 1'b1;
            if (edge_status == STATUS_OK) begin
                n_count = r_count + 1'b1;
            end
        end
        if (i_cmd.start_sort) begin
            n_visited = '0;
            n_x       = '0;
            n_done    = '0;
            n_sp      = '0;
        end
        if (i_cmd.skip_start) begin
            n_x = r_x + 1'b1;
        end
        if (i_cmd.enter_start) begin
            n_visited[r_x[VW-1:0]] = 1'b1;
            n_cur = r_x[VW-1:0];
            n_j   = '0;
            n_x   = r_x + 1'b1;
        end
        if (i_cmd.scan_next) begin
            n_j = j_inc[CW-1:0];
        end
        if (i_cmd.push) begin
            n_visited[e_dst_x[VW-1:0]] = 1'b1;
            n_cur = e_dst_x[VW-1:0];
            n_j   = '0;
            n_sp  = r_sp + 1'b1;
        end
        if (i_cmd.finish) begin
            n_done = r_done + 1'b1;
            if (r_sp != '0) begin
                n_sp = r_sp - 1'b1;
            end
        end
        if (i_cmd.restore) begin
            n_cur = s_vtx;
            n_j   = s_j;
        end
        if (i_cmd.emit_init) begin
            n_k = VW'(r_done - 1'b1);
        end
        if (i_cmd.emit_load) begin
            n_out_valid  = 1'b1;
            n_out.kind   = KIND_VERTEX;
            n_out.status = STATUS_OK;
            n_out.vertex = f_ext[VERTEX_W-1:0];
            n_out.last   = r_k == '0;
            if (r_k != '0) begin
                n_k = r_k - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg       <= CFG_RESET;
            r_count     <= '0;
            r_visited   <= '0;
            r_x         <= '0;
            r_done      <= '0;
            r_sp        <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_cfg       <= n_cfg;
            r_count     <= n_count;
            r_visited   <= n_visited;
            r_x         <= n_x;
            r_done      <= n_done;
            r_sp        <= n_sp;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
        r_j   <= n_j;
        r_out <= n_out;
    end

    // edge table: one write on a stored edge, one read per cycle at the next scan index
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept_edge && edge_status == STATUS_OK) begin
            r_edge_mem[r_count[AW-1:0]] <= '{src: i_in_data.src_vertex,
                                             dst: i_in_data.dst_vertex};
        end
        r_edata <= r_edge_mem[n_j[AW-1:0]];
    end

    // saved frames of suspended vertices; top of stack read ahead for a pop
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_stk_mem[r_sp] <= {r_cur, j_inc[CW-1:0]};
        end
        r_sdata <= r_stk_mem[r_sp - 1'b1];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_fin_mem[r_done[VW-1:0]] <= r_cur;
        end
        r_fdata <= r_fin_mem[r_k];
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> rtl/dts_ctrl.sv
module dts_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_cmd,
    input  logic               i_cfg_valid,
    input  dts_pkg::t_dts_sts  i_sts,
    output logic               o_in_stall,
    output logic               o_cfg_ready,
    output dts_pkg::t_dts_cmd  o_cmd
);
    import dts_pkg::*;

    t_dts_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid && i_sts.out_free && i_in_cmd == CMD_SORT) begin
                    n_state = ST_START;
                end
            end
            ST_START: begin
                if (i_sts.x_end) begin
                    n_state = i_sts.done_zero ? ST_IDLE : ST_EMIT_RD;
                end else if (!i_sts.x_visited) begin
                    n_state = i_sts.cnt_zero ? ST_FINISH : ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (!i_sts.hit && i_sts.j_end) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                n_state = i_sts.sp_zero ? ST_START : ST_RESTORE;
            end
            ST_RESTORE: begin
                n_state = i_sts.rest_end ? ST_FINISH : ST_CHECK;
            end
            ST_EMIT_RD: begin
                n_state = ST_EMIT_SEND;
            end
            ST_EMIT_SEND: begin
                if (i_sts.out_free) begin
                    n_state = i_sts.k_zero ? ST_IDLE : ST_EMIT_RD;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        o_cfg_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_cfg_ready     = 1'b1;
                o_in_stall      = !i_sts.out_free;
                o_cmd.cfg_write = i_cfg_valid;
                if (i_in_valid && i_sts.out_free) begin
                    o_cmd.accept_edge = i_in_cmd == CMD_EDGE;
                    o_cmd.start_sort  = i_in_cmd == CMD_SORT;
                end
            end
            ST_START: begin
                if (i_sts.x_end) begin
                    o_cmd.emit_init = !i_sts.done_zero;
                end else if (i_sts.x_visited) begin
                    o_cmd.skip_start = 1'b1;
                end else begin
                    o_cmd.enter_start = 1'b1;
                end
            end
            ST_CHECK: begin
                if (i_sts.hit) begin
                    o_cmd.push = 1'b1;
                end else if (!i_sts.j_end) begin
                    o_cmd.scan_next = 1'b1;
                end
            end
            ST_FINISH: begin
                o_cmd.finish = 1'b1;
            end
            ST_RESTORE: begin
                o_cmd.restore = 1'b1;
            end
            ST_EMIT_RD: begin
                o_cmd = '0;
            end
            ST_EMIT_SEND: begin
                o_cmd.emit_load = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule
